// ----- rtl/utbd_pkg.sv -----
// shared types, constants and helpers for the unsigned to base digit string block
// no dependencies
package utbd_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 64;

  // dividend bits retired per divider cycle
  localparam int STEP_BITS = 8;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 7;

  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;
  localparam int RADIX_RESET = 10;

  localparam int DECIMAL_LIMIT = 10;
  localparam int CHAR_ZERO     = 48;
  localparam int CHAR_A        = 65;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_load;
  } utbd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_last;
    logic more;
    logic out_free;
    logic rd_zero;
  } utbd_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    if (d < RADIX_W'(DECIMAL_LIMIT)) begin
      return CHAR_W'(CHAR_ZERO) + CHAR_W'(d);
    end else begin
      return CHAR_W'(CHAR_A - DECIMAL_LIMIT) + CHAR_W'(d);
    end
  endfunction

endpackage

// ----- rtl/utbd_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
module utbd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/utbd_ctrl.sv -----
// sequencing fsm: divide, store digit, then read back and emit digits
// depends on utbd_pkg
module utbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  utbd_pkg::utbd_sts_t sts,
  output utbd_pkg::utbd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.more ? S_DIV : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = sts.rd_zero ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/utbd_dp.sv -----
// datapath: radix register, radix divider, digit store and output register
// depends on utbd_pkg and utbd_ram
module utbd_dp #(
  parameter int VALUE_WIDTH = utbd_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = utbd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [utbd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  input  utbd_pkg::utbd_cmd_t           cmd,
  output utbd_pkg::utbd_sts_t           sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [utbd_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last,
  output logic [utbd_pkg::COUNT_W-1:0]  out_digit_count
);

  localparam int RW    = utbd_pkg::RADIX_W;
  localparam int SB    = utbd_pkg::STEP_BITS;
  localparam int STEPS = (VALUE_WIDTH + SB - 1) / SB;
  localparam int PAD_W = STEPS * SB;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CW    = $clog2(MAX_DIGITS + 1);

  logic [RW-1:0]    radix_r, radix_nxt;
  logic [PAD_W-1:0] work_r, work_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    cnt_inc;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [utbd_pkg::CHAR_W-1:0]  out_char_r;
  logic                         out_last_r;
  logic [utbd_pkg::COUNT_W-1:0] out_count_r;

  logic [RW-1:0] step_rem;
  logic [SB-1:0] step_q;
  logic [RW-1:0] ram_rdata;

  // saturate a radix write into the legal range
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we) begin
      if (cfg_data < RW'(utbd_pkg::RADIX_MIN)) begin
        radix_nxt = RW'(utbd_pkg::RADIX_MIN);
      end else if (cfg_data > RW'(utbd_pkg::RADIX_MAX)) begin
        radix_nxt = RW'(utbd_pkg::RADIX_MAX);
      end else begin
        radix_nxt = cfg_data;
      end
    end
  end

  // restoring long division, one dividend byte per cycle
  always_comb begin
    logic [RW:0] r;
    logic [RW-1:0] rv;
    rv     = rem_r;
    step_q = '0;
    for (int i = 0; i < SB; i++) begin
      r = {rv, work_r[PAD_W-1-i]};
      if (r >= {1'b0, radix_r}) begin
        r              = r - {1'b0, radix_r};
        step_q[SB-1-i] = 1'b1;
      end
      rv = r[RW-1:0];
    end
    step_rem = rv;
  end

  assign cnt_inc = cnt_r + CW'(1);

  always_comb begin
    work_nxt   = work_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.load) begin
      work_nxt = PAD_W'(in_value);
      rem_nxt  = '0;
      step_nxt = '0;
      cnt_nxt  = '0;
    end
    if (cmd.div_step) begin
      work_nxt = (work_r << SB) | PAD_W'(step_q);
      rem_nxt  = step_rem;
      step_nxt = step_r + SW'(1);
    end
    if (cmd.store) begin
      rem_nxt    = '0;
      step_nxt   = '0;
      cnt_nxt    = cnt_inc;
      rd_idx_nxt = cnt_r[AW-1:0];
    end
    if (cmd.emit_load) begin
      rd_idx_nxt = rd_idx_r - AW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RW'(utbd_pkg::RADIX_RESET);
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cnt_r       <= '0;
      work_r      <= '0;
    end else begin
      radix_r     <= radix_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      work_r      <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (cmd.emit_load) begin
      out_char_r  <= utbd_pkg::digit_to_ascii(ram_rdata);
      out_last_r  <= (rd_idx_r == '0);
      out_count_r <= utbd_pkg::COUNT_W'(cnt_r);
    end
  end

  utbd_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .we      (cmd.store),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   (rem_r),
    .raddr   (rd_idx_r),
    .rdata_r (ram_rdata)
  );

  assign sts.step_last = (step_r == SW'(STEPS - 1));
  assign sts.more      = (work_r != '0) && (cnt_inc < CW'(MAX_DIGITS));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.rd_zero   = (rd_idx_r == '0);

  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_last        = out_last_r;
  assign out_digit_count = out_count_r;

endmodule

// ----- rtl/unsigned_to_base_digit_string_top.sv -----
// top level of the unsigned to base digit string converter
// depends on utbd_pkg, utbd_ctrl, utbd_dp (and utbd_ram below it)
//
// usage:
//   cfg channel: cfg_valid/cfg_ready carry a 6-bit radix write, saturated into 2..36,
//     reset value 10. cfg_ready is always high; write only while the block is idle.
//   in channel: one request per value (in_valid/in_ready/in_value). in_ready is high
//     whenever no conversion is in flight, including while the final digit still
//     sits in the output register waiting to be taken.
//   out channel: one request per digit, most significant first, ascii '0'-'9' or
//     'A'-'Z', out_last on the final digit, out_digit_count on every digit.
// sequence per digit: the divider walks every dividend byte, then a store step writes
//   the remainder as the digit; the divider retires eight dividend bits per cycle
//   through a chain of narrow compare/subtracts.
//   read-back runs a store read step and an output load step per digit; the output
//   load step waits while the output register still holds an untaken digit.
// stall: a low out_ready holds the current digit and freezes read-back; nothing
//   is lost or repeated.
// reset: synchronous, active low; drops all requests and sets the radix to 10.
module unsigned_to_base_digit_string_top #(
  parameter int VALUE_WIDTH = utbd_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = utbd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [utbd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utbd_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                          out_last,
  output logic [utbd_pkg::COUNT_W-1:0]  out_digit_count
);

  utbd_pkg::utbd_cmd_t cmd;
  utbd_pkg::utbd_sts_t sts;

  // radix register is always writable
  assign cfg_ready = 1'b1;

  // sequencing only; all data storage sits in the datapath
  utbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // divider, digit store, read-back and output register
  utbd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_digit_char  (out_digit_char),
    .out_last        (out_last),
    .out_digit_count (out_digit_count)
  );

endmodule

// ----- rtl/utbd_checker.sv -----
// port-level checks for the digit string converter, bound to the top level
// depends on utbd_pkg and unsigned_to_base_digit_string_top
module utbd_checker #(
  parameter int MAX_DIGITS = utbd_pkg::MAX_DIGITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [utbd_pkg::CHAR_W-1:0]   out_digit_char,
  input logic                          out_last,
  input logic [utbd_pkg::COUNT_W-1:0]  out_digit_count
);

  // reset drops the output request
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled digit holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_last) && $stable(out_digit_count))
    else $error("stalled digit changed");

  // no new value is taken while digits other than the last remain
  a_no_accept_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("in_ready high while a string is being emitted");

  a_char_alnum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 7'd48 && out_digit_char <= 7'd57)
      || (out_digit_char >= 7'd65 && out_digit_char <= 7'd90))
    else $error("digit character outside 0-9 and A-Z");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count != '0
      && out_digit_count <= utbd_pkg::COUNT_W'(MAX_DIGITS))
    else $error("digit count out of range");

endmodule

bind unsigned_to_base_digit_string_top utbd_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_utbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digit_char  (out_digit_char),
  .out_last        (out_last),
  .out_digit_count (out_digit_count)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for unsigned_to_base_digit_string_top: directed and random values
// across radix settings, with digit-by-digit prediction and randomized valid/ready timing
// depends on utbd_pkg and the converter rtl only
module tb_top;

  localparam int VALUE_BITS    = utbd_pkg::VALUE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 800;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_ITEMS  = 320;

  // one digit request as it should leave the block
  typedef struct packed {
    logic [utbd_pkg::CHAR_W-1:0]  ch;
    logic                         last;
    logic [utbd_pkg::COUNT_W-1:0] count;
  } digit_req_t;

  // receiver behavior between long holds
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_mode_t;

  // kinds of random value
  typedef enum int {PICK_FULL, PICK_SMALL, PICK_SHIFTED, PICK_BOUNDARY, PICK_EDGE} pick_kind_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [utbd_pkg::RADIX_W-1:0]   cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [VALUE_BITS-1:0]          in_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [utbd_pkg::CHAR_W-1:0]    out_digit_char;
  logic                           out_last;
  logic [utbd_pkg::COUNT_W-1:0]   out_digit_count;

  // predicted digits still to come, oldest first
  digit_req_t         pending_digits[$];
  digit_req_t         digit_due;
  int                 fault_count = 0;
  // radix as the block should hold it after saturation
  logic [utbd_pkg::RADIX_W-1:0] radix_now = utbd_pkg::RADIX_W'(utbd_pkg::RADIX_RESET);
  // sender burst bookkeeping
  int                 burst_left = 1;
  // long receiver holds asked for by the tests, and granted by the receiver
  int                 hold_asks = 0;
  int                 holds_done = 0;
  int                 hold_left = 0;
  ready_mode_t        ready_mode = READY_ALWAYS;
  int                 mode_left = 0;
  logic [3:0]         ready_tick = '0;

  int unsigned radix_extremes[6] = '{0, 1, 2, 36, 37, 63};

  unsigned_to_base_digit_string_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_char  (out_digit_char),
    .out_last        (out_last),
    .out_digit_count (out_digit_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // repeated division gives digits least significant first; queue them most significant first
  function automatic void queue_digit_string(input logic [VALUE_BITS-1:0] value);
    logic [utbd_pkg::RADIX_W-1:0] digits [64];
    logic [VALUE_BITS-1:0]        quotient;
    logic [VALUE_BITS-1:0]        base;
    int                           n;
    digit_req_t                   req;
    quotient = value;
    base     = VALUE_BITS'(radix_now);
    n        = 0;
    do begin
      digits[n] = utbd_pkg::RADIX_W'(quotient % base);
      quotient  = quotient / base;
      n++;
    end while (quotient != 0 && n < utbd_pkg::MAX_DIGITS_DEF);
    for (int k = n - 1; k >= 0; k--) begin
      // '0'-'9' below ten, 'A'-'Z' from ten up
      if (digits[k] < utbd_pkg::DECIMAL_LIMIT) begin
        req.ch = utbd_pkg::CHAR_W'(utbd_pkg::CHAR_ZERO + digits[k]);
      end else begin
        req.ch = utbd_pkg::CHAR_W'(utbd_pkg::CHAR_A - utbd_pkg::DECIMAL_LIMIT + digits[k]);
      end
      req.last  = (k == 0);
      req.count = utbd_pkg::COUNT_W'(n);
      pending_digits.push_back(req);
    end
  endfunction

  // random value, biased toward digit-count boundaries of the current radix
  function automatic logic [VALUE_BITS-1:0] pick_value();
    pick_kind_t            kind;
    logic [VALUE_BITS-1:0] power;
    logic [VALUE_BITS-1:0] full;
    int                    steps;
    full = {$urandom, $urandom};
    kind = pick_kind_t'($urandom_range(0, 4));
    case (kind)
      PICK_SMALL: begin
        return VALUE_BITS'($urandom_range(0, 2000));
      end
      PICK_SHIFTED: begin
        return full >> $urandom_range(1, VALUE_BITS - 1);
      end
      PICK_BOUNDARY: begin
        // radix^k or radix^k - 1, k capped where the power would overflow
        power = 1;
        steps = $urandom_range(1, VALUE_BITS);
        repeat (steps) begin
          if (power <= {VALUE_BITS{1'b1}} / radix_now) begin
            power = power * radix_now;
          end
        end
        return ($urandom_range(0, 1) != 0) ? power : power - 1'b1;
      end
      PICK_EDGE: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return VALUE_BITS'(1);
          default: return '1;
        endcase
      end
      default: begin
        return full;
      end
    endcase
  endfunction

  // send one value request; valid stays up into the next request unless a gap follows
  task automatic offer_value(input logic [VALUE_BITS-1:0] value);
    int gap;
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    queue_digit_string(value);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      // sometimes no gap at all, mostly short gaps, now and then one longer than a conversion
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
      end else if ($urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 300);
      end else begin
        gap = $urandom_range(1, 30);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender pauses until every predicted digit has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // radix write, only with the block idle
  task automatic write_radix(input logic [utbd_pkg::RADIX_W-1:0] raw);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (raw < utbd_pkg::RADIX_MIN) begin
      radix_now = utbd_pkg::RADIX_W'(utbd_pkg::RADIX_MIN);
    end else if (raw > utbd_pkg::RADIX_MAX) begin
      radix_now = utbd_pkg::RADIX_W'(utbd_pkg::RADIX_MAX);
    end else begin
      radix_now = raw;
    end
  endtask

  // decimal at the reset radix: zero, one digit, carries to two and three digits, all ones, top bit only
  task automatic test_reset_radix();
    offer_value('0);
    offer_value(VALUE_BITS'(1));
    offer_value(VALUE_BITS'(9));
    offer_value(VALUE_BITS'(10));
    offer_value(VALUE_BITS'(99));
    offer_value(VALUE_BITS'(100));
    offer_value('1);
    offer_value(64'h8000_0000_0000_0000);
  endtask

  // writes below 2 and above 36 saturate; base 2 all ones gives the full 64 digits
  task automatic test_radix_saturation();
    write_radix(utbd_pkg::RADIX_W'(0));
    offer_value(VALUE_BITS'(5));
    write_radix(utbd_pkg::RADIX_W'(1));
    offer_value('1);
    write_radix(utbd_pkg::RADIX_W'(37));
    offer_value(VALUE_BITS'(35));
    write_radix(utbd_pkg::RADIX_W'(63));
    offer_value('1);
    write_radix(utbd_pkg::RADIX_W'(36));
    offer_value(VALUE_BITS'(36));
    offer_value('0);
  endtask

  // every hex letter digit shows up, and Z in base 36
  task automatic test_letter_digits();
    write_radix(utbd_pkg::RADIX_W'(16));
    offer_value(64'hFEDC_BA98_7654_3210);
    offer_value(64'h0123_4567_89AB_CDEF);
    write_radix(utbd_pkg::RADIX_W'(36));
    offer_value(VALUE_BITS'(35));
    offer_value(VALUE_BITS'(1295));
    offer_value(VALUE_BITS'(1679615));
  endtask

  // receiver holds off for a long stretch while requests keep coming, so in_ready drops
  task automatic test_receiver_hold();
    write_radix(utbd_pkg::RADIX_W'(10));
    hold_asks <= hold_asks + 1;
    repeat (6) offer_value(pick_value());
    wait_idle();
  endtask

  // random phases, each with its own radix, raw register values included
  task automatic test_random_phases();
    int                           sent;
    int                           phase_items;
    logic [utbd_pkg::RADIX_W-1:0] raw;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        raw = utbd_pkg::RADIX_W'(radix_extremes[$urandom_range(0, 5)]);
      end else begin
        raw = utbd_pkg::RADIX_W'($urandom_range(0, 63));
      end
      write_radix(raw);
      phase_items = $urandom_range(20, 50);
      repeat (phase_items) begin
        offer_value(pick_value());
        sent++;
      end
    end
  endtask

  // receiver: long holds on request, otherwise a ready mode redrawn at random intervals
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    if (hold_asks != holds_done) begin
      holds_done = hold_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 400);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:      out_ready <= ready_tick[1] ^ ready_tick[3];
      endcase
    end
  end

  // every accepted digit request against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: ERROR digit with none pending: char %0d last %0d count %0d",
                 $time, out_digit_char, out_last, out_digit_count);
        fault_count++;
      end else begin
        digit_due = pending_digits.pop_front();
        if (out_digit_char !== digit_due.ch) begin
          $display("%0t: ERROR digit_char expected %0d got %0d",
                   $time, digit_due.ch, out_digit_char);
          fault_count++;
        end
        if (out_last !== digit_due.last) begin
          $display("%0t: ERROR last expected %0d got %0d", $time, digit_due.last, out_last);
          fault_count++;
        end
        if (out_digit_count !== digit_due.count) begin
          $display("%0t: ERROR digit_count expected %0d got %0d",
                   $time, digit_due.count, out_digit_count);
          fault_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_radix();
    test_radix_saturation();
    test_letter_digits();
    test_receiver_hold();
    test_random_phases();
    // drain, then leave room for any stray digit request
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("unsigned_to_base_digit_string_top: match");
    end else begin
      $display("unsigned_to_base_digit_string_top: mismatch");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("unsigned_to_base_digit_string_top: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/utbd_pkg.sv
rtl/utbd_ram.sv
rtl/utbd_ctrl.sv
rtl/utbd_dp.sv
rtl/unsigned_to_base_digit_string_top.sv
rtl/utbd_checker.sv
test/tb_top.sv
